@@ design/lgw_pkg.sv @@
// Package for the LCD display-RAM window address writer.
// Types, register indexes and fixed limits shared by all design files.
`default_nettype none
package lgw_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_PHASE  = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BPP          = 8'd7;

  localparam int SCAN_VERT = 0;
  localparam int SCAN_XDEC = 1;
  localparam int SCAN_YDEC = 2;

  typedef struct packed {
    logic [9:0] panel_width;
    logic [9:0] panel_height;
    logic [8:0] win_left;
    logic [8:0] win_right;
    logic [8:0] win_top;
    logic [8:0] win_bottom;
    logic [2:0] scan_mode;
    logic [1:0] bytes_per_pixel;
  } cfg_t;

  // one classified item on its way to the address stage
  typedef struct packed {
    logic       write_enable;
    logic       pixel_complete;
    logic [7:0] write_data;
    logic [8:0] col;
    logic [8:0] row;
    logic [9:0] width;
    logic       bpp3;
    logic [1:0] phase;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    q_entry_t entry;
  } q_status_t;

endpackage
`default_nettype wire

@@ design/lgw_if.sv @@
// Channel interfaces of the window address writer: input, result, config.
// Depends on lgw_pkg for the config field widths.
`default_nettype none
interface lgw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [8:0] set_x;
  logic [8:0] set_y;
  modport source (output valid, kind, data_byte, set_x, set_y, input ready);
  modport sink   (input valid, kind, data_byte, set_x, set_y, output ready);
endinterface

interface lgw_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [19:0] byte_address;
  logic [7:0]  write_data;
  logic        pixel_complete;
  modport source (output valid, write_enable, byte_address, write_data, pixel_complete,
                  input ready);
  modport sink   (input valid, write_enable, byte_address, write_data, pixel_complete,
                  output ready);
endinterface

interface lgw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lgw_pkg::CFG_IDX_W-1:0]  index;
  logic [lgw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/lgw_front.sv @@
// Front end: accepts items, holds cursor and byte phase, classifies each beat.
// Depends on lgw_pkg and lgw_in_if; pushes entries into lgw_queue.
`default_nettype none
module lgw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lgw_in_if.sink                 in_ch,
  input  wire lgw_pkg::cfg_t     cfg,
  input  wire logic              q_full,
  output logic                   q_push,
  output lgw_pkg::q_entry_t      q_entry
);

  logic [8:0] cursor_x_r, cursor_x_nxt;
  logic [8:0] cursor_y_r, cursor_y_nxt;
  logic [1:0] byte_phase_r, byte_phase_nxt;

  logic [9:0] w, h;
  logic       bpp3;
  logic [1:0] bpp;
  logic [1:0] phase;
  logic [2:0] phase_inc;
  logic       last;
  logic       in_panel;
  logic [9:0] nx, ny;
  logic [8:0] sx, sy;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    w = (cfg.panel_width > 10'(lgw_pkg::MAX_WIDTH)) ? 10'(lgw_pkg::MAX_WIDTH)
                                                    : cfg.panel_width;
    h = (cfg.panel_height > 10'(lgw_pkg::MAX_HEIGHT)) ? 10'(lgw_pkg::MAX_HEIGHT)
                                                      : cfg.panel_height;
    bpp3      = (cfg.bytes_per_pixel == 2'd3);
    bpp       = bpp3 ? 2'd3 : 2'd2;
    phase     = (byte_phase_r >= bpp) ? 2'd0 : byte_phase_r;
    phase_inc = {1'b0, phase} + 3'd1;
    last      = (phase_inc >= {1'b0, bpp});
    in_panel  = ({1'b0, cursor_x_r} < w) && ({1'b0, cursor_y_r} < h);

    // cursor step inside the window
    nx = {1'b0, cursor_x_r};
    ny = {1'b0, cursor_y_r};
    if (cfg.scan_mode[lgw_pkg::SCAN_VERT]) begin
      ny = ny + 10'd1;
      if (ny > {1'b0, cfg.win_bottom}) begin
        ny = {1'b0, cfg.win_top};
        nx = nx + 10'd1;
        if (nx > {1'b0, cfg.win_right}) nx = {1'b0, cfg.win_left};
      end
    end else begin
      nx = nx + 10'd1;
      if (nx > {1'b0, cfg.win_right}) begin
        nx = {1'b0, cfg.win_left};
        ny = ny + 10'd1;
        if (ny > {1'b0, cfg.win_bottom}) ny = {1'b0, cfg.win_top};
      end
    end
    sx = nx[8:0];
    sy = ny[8:0];

    q_entry                = '0;
    cursor_x_nxt           = cursor_x_r;
    cursor_y_nxt           = cursor_y_r;
    byte_phase_nxt         = byte_phase_r;
    unique case (in_ch.kind)
      lgw_pkg::KIND_PIXEL: begin
        q_entry.write_enable   = in_panel;
        q_entry.pixel_complete = last;
        q_entry.write_data     = in_ch.data_byte;
        q_entry.col   = cfg.scan_mode[lgw_pkg::SCAN_XDEC]
                        ? 9'(w - 10'd1 - {1'b0, cursor_x_r}) : cursor_x_r;
        q_entry.row   = cfg.scan_mode[lgw_pkg::SCAN_YDEC]
                        ? 9'(h - 10'd1 - {1'b0, cursor_y_r}) : cursor_y_r;
        q_entry.width = w;
        q_entry.bpp3  = bpp3;
        q_entry.phase = phase;
        if (last) begin
          byte_phase_nxt = 2'd0;
          cursor_x_nxt   = sx;
          cursor_y_nxt   = sy;
        end else begin
          byte_phase_nxt = phase_inc[1:0];
        end
      end
      lgw_pkg::KIND_CURSOR: begin
        cursor_x_nxt = in_ch.set_x;
        cursor_y_nxt = in_ch.set_y;
      end
      lgw_pkg::KIND_PHASE: begin
        byte_phase_nxt = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      byte_phase_r <= '0;
    end else if (accept) begin
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      byte_phase_r <= byte_phase_nxt;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_phase_r != 2'd3)
    else $error("byte phase out of range");

endmodule
`default_nettype wire

@@ design/lgw_queue.sv @@
// Two-entry queue between the front end and the address stage.
// Depends on lgw_pkg for the entry and status types.
`default_nettype none
module lgw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lgw_pkg::q_entry_t  push_entry,
  input  wire logic               pop,
  output lgw_pkg::q_status_t      status
);

  localparam int CNT_W = $clog2(lgw_pkg::QDEPTH + 1);

  lgw_pkg::q_entry_t                 slot_r [lgw_pkg::QDEPTH];
  logic [lgw_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [lgw_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic                              do_push, do_pop;

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == CNT_W'(lgw_pkg::QDEPTH));
  assign status.entry = slot_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == lgw_pkg::QPTR_W'(lgw_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + lgw_pkg::QPTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == lgw_pkg::QPTR_W'(lgw_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + lgw_pkg::QPTR_W'(1);
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(lgw_pkg::QDEPTH))
    else $error("queue count overrun");

endmodule
`default_nettype wire

@@ design/lgw_back.sv @@
// Address stage: row * width + col, then times 3 if bytes per pixel is 3, else 2, plus phase.
// Depends on lgw_pkg and lgw_out_if; pops entries from lgw_queue.
`default_nettype none
module lgw_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lgw_pkg::q_status_t  q_status,
  output logic                     q_pop,
  lgw_out_if.source                out_ch
);

  // stage 1: pixel index
  logic        s1_valid_r;
  logic        s1_we_r, s1_complete_r, s1_bpp3_r;
  logic [7:0]  s1_data_r;
  logic [1:0]  s1_phase_r;
  logic [18:0] s1_idx_r, s1_idx_nxt;

  // stage 2: result register
  logic        o_valid_r;
  logic        o_we_r, o_complete_r;
  logic [7:0]  o_data_r;
  logic [19:0] o_addr_r, o_addr_nxt;

  logic out_take, s1_go, s1_load;

  assign out_take = !o_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && out_take;
  assign s1_load  = !s1_valid_r || s1_go;
  assign q_pop    = q_status.valid && s1_load;

  always_comb begin
    s1_idx_nxt = ({10'd0, q_status.entry.row} * {9'd0, q_status.entry.width})
                 + {10'd0, q_status.entry.col};
    o_addr_nxt = {s1_idx_r, 1'b0} + (s1_bpp3_r ? {1'b0, s1_idx_r} : 20'd0)
                 + {18'd0, s1_phase_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (s1_load) s1_valid_r <= q_status.valid;
      if (out_take) o_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_we_r       <= q_status.entry.write_enable;
      s1_complete_r <= q_status.entry.pixel_complete;
      s1_bpp3_r     <= q_status.entry.bpp3;
      s1_data_r     <= q_status.entry.write_data;
      s1_phase_r    <= q_status.entry.phase;
      s1_idx_r      <= s1_idx_nxt;
    end
    if (s1_go) begin
      o_we_r       <= s1_we_r;
      o_complete_r <= s1_complete_r;
      o_data_r     <= s1_we_r ? s1_data_r : 8'd0;
      o_addr_r     <= s1_we_r ? o_addr_nxt : 20'd0;
    end
  end

  assign out_ch.valid          = o_valid_r;
  assign out_ch.write_enable   = o_we_r;
  assign out_ch.byte_address   = o_addr_r;
  assign out_ch.write_data     = o_data_r;
  assign out_ch.pixel_complete = o_complete_r;

  a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && !o_we_r) |-> (o_addr_r == 20'd0 && o_data_r == 8'd0))
    else $error("suppressed write carries payload");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_we_r) |-> (o_addr_r < 20'd786432))
    else $error("byte address beyond frame buffer");

endmodule
`default_nettype wire

@@ design/lcd_gram_window_address_writer.sv @@
// Channel    Dir   Payload
// in_ch      in    kind, data_byte, set_x, set_y
// out_ch     out   write_enable, byte_address, write_data, pixel_complete
// cfg_ch     in    index, data (always ready)
//
// One item per cycle sustained while out_ch takes results. The front end updates
// cursor and phase on accept; the back end registers row * width + col in stage 1,
// then the byte address from index, bytes per pixel and phase in the result register.
// A two-entry queue decouples them; in_ch stalls only when the queue is full.
// Synchronous active-low reset clears cursor, phase, queue and restores config.
// Top level of the LCD display-RAM window address writer.
// Depends on lgw_pkg, lgw_if, lgw_front, lgw_queue and lgw_back.
`default_nettype none
module lcd_gram_window_address_writer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lgw_in_if.sink     in_ch,
  lgw_out_if.source  out_ch,
  lgw_cfg_if.sink    cfg_ch
);

  lgw_pkg::cfg_t      cfg_r;
  lgw_pkg::q_status_t q_status;
  lgw_pkg::q_entry_t  q_entry;
  logic               q_push, q_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width     <= 10'd240;
      cfg_r.panel_height    <= 10'd320;
      cfg_r.win_left        <= 9'd0;
      cfg_r.win_right       <= 9'd239;
      cfg_r.win_top         <= 9'd0;
      cfg_r.win_bottom      <= 9'd319;
      cfg_r.scan_mode       <= 3'd0;
      cfg_r.bytes_per_pixel <= 2'd2;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        lgw_pkg::REG_PANEL_WIDTH:  cfg_r.panel_width     <= cfg_ch.data[9:0];
        lgw_pkg::REG_PANEL_HEIGHT: cfg_r.panel_height    <= cfg_ch.data[9:0];
        lgw_pkg::REG_WIN_LEFT:     cfg_r.win_left        <= cfg_ch.data[8:0];
        lgw_pkg::REG_WIN_RIGHT:    cfg_r.win_right       <= cfg_ch.data[8:0];
        lgw_pkg::REG_WIN_TOP:      cfg_r.win_top         <= cfg_ch.data[8:0];
        lgw_pkg::REG_WIN_BOTTOM:   cfg_r.win_bottom      <= cfg_ch.data[8:0];
        lgw_pkg::REG_SCAN_MODE:    cfg_r.scan_mode       <= cfg_ch.data[2:0];
        lgw_pkg::REG_BPP:          cfg_r.bytes_per_pixel <= cfg_ch.data[1:0];
        default: begin
        end
      endcase
    end
  end

  lgw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_full  (q_status.full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  lgw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .status     (q_status)
  );

  lgw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
